@@ rtl/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, constants and helpers for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int SYMBOL_BITS = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int MODE_W      = 2;
  localparam int S_TDATA_W   = ((MODE_W + SYMBOL_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W   = 8;

  typedef logic [SYMBOL_BITS-1:0] sym_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [MAX_PATTERN-1:0] pos_t;
  typedef logic [MAX_PATTERN:0]   act_t;

  localparam sym_t SYM_STAR  = sym_t'(16'h002A);
  localparam sym_t SYM_QMARK = sym_t'(16'h003F);
  localparam len_t LEN_MAX   = len_t'(MAX_PATTERN);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_SUBJECT = 2'd2,
    MODE_FINISH  = 2'd3
  } mode_e;

  // Star closure as one carry chain: a carry entering a bit means that
  // position is reached from an active position through a run of stars.
  function automatic act_t close_stars(act_t act, act_t star);
    act_t gen;
    act_t sum;
    gen = act & star;
    sum = star + gen;
    return act | (sum ^ star ^ gen);
  endfunction

endpackage

@@ rtl/wildcard_glob_matcher.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Matches a streamed subject against a loaded glob pattern ('*' and '?').
//
//   channel   dir  fields (lsb first)                    result
//   s_axis    in   mode[1:0], symbol[17:2], pad to 24    none
//   m_axis    out  matched[0], pattern_overflow[1], pad  one per finish item
//
// One item per cycle while no finish item waits: an input register, then
// compare, step and star closure (a single 33-bit carry chain) in combinational logic, then the state and result regs.
// A finish item's result is loaded into the result register as the item leaves the input register.
// Reset empties the pattern and leaves only position zero active.
// A finish item waits in the input register only while the result register
// is full and not being taken; other items never wait there, but can be held behind it.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
  import wgm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // mode[1:0], symbol[17:2], zeros
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o   // matched[0], pattern_overflow[1], zeros
);

  // input register
  logic  in_vld_q;
  mode_e mode_q;
  sym_t  sym_q;

  // pattern state
  sym_t  store_q [MAX_PATTERN];
  pos_t  vld_q, vld_d;
  pos_t  star_q, star_d;
  pos_t  qm_q, qm_d;
  len_t  len_q, len_d;
  logic  ovf_q, ovf_d;
  act_t  act_q, act_d;

  // result register
  logic  out_vld_q;
  logic  matched_q, ovf_out_q;

  logic  out_free;
  logic  advance;
  logic  fire;
  logic  wr_en;
  idx_t  wr_idx;
  pos_t  hit;
  pos_t  step;
  pos_t  stay;
  act_t  nxt;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = !(in_vld_q && (mode_q == MODE_FINISH) && !out_free);
  assign fire            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign wr_idx          = len_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_CLEAR;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
      if (s_axis_tvalid_i) begin
        mode_q <= mode_e'(s_axis_tdata_i[MODE_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      sym_q <= s_axis_tdata_i[MODE_W +: SYMBOL_BITS];
    end
  end

  // one compare per pattern slot against the subject symbol
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit[i] = qm_q[i] || (store_q[i] == sym_q);
    end
  end

  assign stay = act_q[MAX_PATTERN-1:0] & star_q;
  assign step = act_q[MAX_PATTERN-1:0] & vld_q & ~star_q & hit;
  assign nxt  = {1'b0, stay} | {step, 1'b0};

  always_comb begin
    vld_d  = vld_q;
    star_d = star_q;
    qm_d   = qm_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    act_d  = act_q;
    wr_en  = 1'b0;
    if (fire) begin
      unique case (mode_q)
        MODE_CLEAR: begin
          vld_d  = '0;
          star_d = '0;
          qm_d   = '0;
          len_d  = '0;
          ovf_d  = 1'b0;
          act_d  = act_t'(1);
        end
        MODE_APPEND: begin
          if (sym_q != '0) begin
            if (len_q < LEN_MAX) begin
              wr_en          = 1'b1;
              vld_d[wr_idx]  = 1'b1;
              star_d[wr_idx] = (sym_q == SYM_STAR);
              qm_d[wr_idx]   = (sym_q == SYM_QMARK);
              len_d          = len_q + len_t'(1);
            end else begin
              ovf_d = 1'b1;
            end
            act_d = close_stars(act_t'(1), {1'b0, star_d});
          end
        end
        MODE_SUBJECT: begin
          if (sym_q != '0) begin
            act_d = close_stars(nxt, {1'b0, star_q});
          end
        end
        MODE_FINISH: begin
          act_d = close_stars(act_t'(1), {1'b0, star_q});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      star_q <= '0;
      qm_q   <= '0;
      len_q  <= '0;
      ovf_q  <= 1'b0;
      act_q  <= act_t'(1);
    end else begin
      vld_q  <= vld_d;
      star_q <= star_d;
      qm_q   <= qm_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= sym_q;
    end
  end

  // result register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && (mode_q == MODE_FINISH)) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && (mode_q == MODE_FINISH)) begin
      matched_q <= act_q[len_q];
      ovf_out_q <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-2){1'b0}}, ovf_out_q, matched_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_vld_thermo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q + pos_t'(1)) & vld_q) == '0)
    else $error("pattern valid bits not contiguous from zero");

  a_vld_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) == int'(len_q))
    else $error("pattern length disagrees with valid bits");

  a_flags_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((star_q | qm_q) & ~vld_q) == '0)
    else $error("symbol flag set beyond pattern length");

  a_act_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q & ~{vld_q, 1'b1}) == '0)
    else $error("active position beyond pattern length");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire && (mode_q == MODE_FINISH)))
    else $error("result raised without a finish item");

endmodule

@@ tb/wildcard_glob_matcher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_tb
// Streams patterns and subjects into the glob matcher. A scoreboard keeps its
// own pattern store and active-position vector, and predicts the verdict of
// every finish item. It checks each result against the oldest prediction.
// Both stream sides idle at random. One long output hold-off fills the block.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_tb
  import wgm_pkg::*;
();

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int ITEM_TARGET    = 1100;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  localparam sym_t SYM_A = sym_t'(16'h0061);
  localparam sym_t SYM_B = sym_t'(16'h0062);
  localparam sym_t SYM_C = sym_t'(16'h0063);

  typedef struct packed {
    logic overflow;
    logic matched;
  } glob_verdict_t;

  class glob_scoreboard;
    sym_t            pat_mem [MAX_PATTERN];
    int unsigned     pat_len;
    act_t            live_pos;
    bit              ovf_seen;
    glob_verdict_t   verdict_q[$];
    int unsigned     errors;
    int unsigned     finishes;
    int unsigned     hits;
    int unsigned     ovf_verdicts;

    function new();
      pat_len  = 0;
      ovf_seen = 1'b0;
      errors   = 0;
      finishes = 0;
      hits     = 0;
      ovf_verdicts = 0;
      foreach (pat_mem[i]) pat_mem[i] = '0;
      restart_subject();
    endfunction

    // Propagate every active star position to the position after it.
    function act_t star_closure(act_t vec);
      for (int i = 0; i < pat_len; i++) begin
        if (vec[i] && pat_mem[i] == SYM_STAR) vec[i+1] = 1'b1;
      end
      return vec;
    endfunction

    function void restart_subject();
      live_pos = star_closure(act_t'(1));
    endfunction

    function void consume_symbol(sym_t sym);
      act_t nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
        if (live_pos[i]) begin
          if (pat_mem[i] == SYM_STAR) nxt[i] = 1'b1;
          else if (pat_mem[i] == SYM_QMARK || pat_mem[i] == sym) nxt[i+1] = 1'b1;
        end
      end
      live_pos = star_closure(nxt);
    endfunction

    function void note_accepted(mode_e mode, sym_t sym);
      glob_verdict_t v;
      case (mode)
        MODE_CLEAR: begin
          pat_len  = 0;
          ovf_seen = 1'b0;
          restart_subject();
        end
        MODE_APPEND: begin
          if (sym != '0) begin
            if (pat_len < MAX_PATTERN) begin
              pat_mem[pat_len] = sym;
              pat_len++;
            end else begin
              ovf_seen = 1'b1;
            end
            restart_subject();
          end
        end
        MODE_SUBJECT: begin
          if (sym != '0) consume_symbol(sym);
        end
        default: begin
          v.matched  = live_pos[pat_len];
          v.overflow = ovf_seen;
          verdict_q.push_back(v);
          finishes++;
          if (v.matched) hits++;
          if (v.overflow) ovf_verdicts++;
          restart_subject();
        end
      endcase
    endfunction

    function void check_verdict(logic [M_TDATA_W-1:0] data);
      glob_verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: tdata %0h with no finish item waiting", data);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (data[0] !== want.matched) begin
        $error("matched mismatch: expected %0b, actual %0b", want.matched, data[0]);
        errors++;
      end
      if (data[1] !== want.overflow) begin
        $error("pattern_overflow mismatch: expected %0b, actual %0b", want.overflow,
               data[1]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_data = '0;  // mode[1:0], symbol[17:2], zeros
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;       // matched[0], pattern_overflow[1], zeros

  glob_scoreboard sb = new();

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;
  bit          drained     = 1'b0;
  sym_t        cur_pat[$];

  wildcard_glob_matcher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Observe both handshakes and guard against a hung block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) sb.note_accepted(mode_e'(s_data[1:0]), sym_t'(s_data[17:2]));
      if (m_valid && m_ready) sb.check_verdict(m_data);
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Receiver: ready runs and stalls of random length, plus one long hold-off.
  initial begin
    int unsigned on_len;
    int unsigned off_len;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req  = 1'b0;
        hold_done = 1'b1;
      end else begin
        on_len  = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
        off_len = $urandom_range(0, 5);
        m_ready <= 1'b1;
        repeat (on_len) @(posedge clk_i);
        if (off_len > 0) begin
          m_ready <= 1'b0;
          repeat (off_len) @(posedge clk_i);
        end
      end
    end
  end

  // Offer one item and hold it until accepted; gaps fall between bursts.
  task automatic push(mode_e mode, sym_t sym);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data  <= S_TDATA_W'({sym, mode});
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    burst_left--;
    if (mode == MODE_CLEAR || mode == MODE_FINISH || sym != '0) items_sent++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic sym_t pick_pattern_sym();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return SYM_A;
    if (r < 40) return SYM_B;
    if (r < 48) return SYM_C;
    if (r < 68) return SYM_STAR;
    if (r < 85) return SYM_QMARK;
    if (r < 98) return sym_t'($urandom);
    return '0;
  endfunction

  function automatic sym_t pick_subject_sym();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return SYM_A;
    if (r < 60) return SYM_B;
    if (r < 72) return SYM_C;
    if (r < 76) return SYM_STAR;
    if (r < 80) return SYM_QMARK;
    if (r < 97) return sym_t'($urandom_range(1, 16'hFFFF));
    return '0;
  endfunction

  // Clear, load a pattern, then a few subjects, each closed by a finish item.
  task automatic run_sequence();
    int unsigned plen;
    int unsigned nsub;
    int unsigned slen;
    sym_t        s;
    push(MODE_CLEAR, sym_t'($urandom));
    plen = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
    cur_pat.delete();
    for (int k = 0; k < plen; k++) begin
      s = pick_pattern_sym();
      push(MODE_APPEND, s);
      if (s != '0 && cur_pat.size() < MAX_PATTERN) cur_pat.push_back(s);
    end
    nsub = $urandom_range(1, 5);
    for (int n = 0; n < nsub; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        // build a subject the pattern should accept
        foreach (cur_pat[i]) begin
          if (cur_pat[i] == SYM_STAR) begin
            repeat ($urandom_range(0, 3)) push(MODE_SUBJECT, pick_subject_sym());
          end else if (cur_pat[i] == SYM_QMARK) begin
            push(MODE_SUBJECT, sym_t'($urandom_range(1, 16'hFFFF)));
          end else begin
            push(MODE_SUBJECT, cur_pat[i]);
          end
        end
      end else begin
        slen = $urandom_range(0, 10);
        repeat (slen) push(MODE_SUBJECT, pick_subject_sym());
      end
      if ($urandom_range(0, 19) == 0) push(mode_e'($urandom_range(0, 3)), sym_t'($urandom));
      push(MODE_FINISH, sym_t'($urandom));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pattern, star and question mark, extreme symbols,
    // ignored zero symbols and an append in the middle of a subject.
    push(MODE_FINISH, sym_t'(16'hFFFF));
    push(MODE_CLEAR, sym_t'(16'hFFFF));
    push(MODE_APPEND, SYM_STAR);
    push(MODE_APPEND, SYM_A);
    push(MODE_APPEND, SYM_QMARK);
    push(MODE_APPEND, sym_t'(16'hFFFF));
    push(MODE_APPEND, '0);
    push(MODE_SUBJECT, sym_t'(16'h0078));
    push(MODE_SUBJECT, SYM_A);
    push(MODE_SUBJECT, SYM_B);
    push(MODE_SUBJECT, '0);
    push(MODE_SUBJECT, sym_t'(16'hFFFF));
    push(MODE_FINISH, '0);
    push(MODE_SUBJECT, SYM_A);
    push(MODE_SUBJECT, SYM_B);
    push(MODE_FINISH, '0);
    push(MODE_SUBJECT, sym_t'(16'h0001));
    push(MODE_FINISH, '0);
    push(MODE_CLEAR, '0);
    push(MODE_FINISH, '0);
    push(MODE_SUBJECT, SYM_A);
    push(MODE_APPEND, SYM_QMARK);
    push(MODE_SUBJECT, SYM_STAR);
    push(MODE_FINISH, '0);
    drain();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_req && !hold_done && items_sent > 400) hold_req = 1'b1;
      if (hold_done && !drained && items_sent > 800) begin
        drain();
        drained = 1'b1;
      end
      run_sequence();
      if ($urandom_range(0, 19) == 0) drain();
    end

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items; checked %0d verdicts, %0d matched, %0d with overflow.",
             items_sent, sb.finishes, sb.hits, sb.ovf_verdicts);
    $display("Random bursts and stalls on both sides, one long output hold-off.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
